// ===== rtl/aad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_pkg: shared types and constants
// Widths, register indexes, status codes and the front-to-back job record.
// ----------------------------------------------------------------------------
package aad_pkg;
	localparam int MaxWidth  = 256;
	localparam int MaxHeight = 256;
	localparam int FracBits  = 16;
	localparam int DimW      = 9;
	localparam int AddrW     = 16;
	localparam int PixW      = 24;
	localparam int WtW       = FracBits + 1;
	localparam int AccW      = 2 * WtW + 8 + 16;
	localparam int AreaW     = 2 * WtW + 2 * 8;

	localparam logic [2:0] REG_SRC_W  = 3'd0;
	localparam logic [2:0] REG_SRC_H  = 3'd1;
	localparam logic [2:0] REG_WANT_W = 3'd2;
	localparam logic [2:0] REG_WANT_H = 3'd3;
	localparam logic [2:0] REG_DEPTH  = 3'd4;
	localparam logic [2:0] REG_RMASK  = 3'd5;
	localparam logic [2:0] REG_GMASK  = 3'd6;
	localparam logic [2:0] REG_BMASK  = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEPTH = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic                bad;
		logic [1:0]          status;
		logic [DimW-1:0]     w;
		logic [DimW-1:0]     tw;
		logic [DimW-1:0]     h;
		logic [DimW-1:0]     th;
		logic [7:0]          col;
		logic [7:0]          row;
	} job_t;
endpackage

// ===== rtl/area_average_downscaler_rgb_pack_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_average_downscaler_rgb_pack_core: area-average downscaler, packed RGB
// Loads source pixels into a 64K-entry store and returns packed averages.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfer (valid/stall): action 0 writes one source pixel at
//   source_index and yields no result; action 1 requests one target pixel.
//   Output transfer (out_valid/out_stall) carries packed_pixel and status.
//   The front stage takes a load transfer every cycle while no compute job
//   is queued or being walked, so the store never changes under a footprint
//   read; it queues up to two compute jobs. The back stage walks the
//   footprint one source pixel at a time. Each compute item takes a pop,
//   the span division, per row the row weight and accumulation of the three
//   channels, per pixel a weight divide and store read, the area, then
//   a pass per channel (mask multiply, divide and handoff). Errors return
//   without a footprint walk. The single-port read of the pixel store and
//   the serial dividers set the rate. Reset clears control state only; the
//   pixel store is undefined until written and needs no clearing pass. While
//   the receiver stalls, the result holds, the back stage waits and the queue
//   fills, then stall rises. Configuration is written over APB; the user must
//   write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module area_average_downscaler_rgb_pack_core import aad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        valid,
	output logic        stall,
	input  logic        action,
	input  logic [15:0] source_index,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  target_col,
	input  logic [7:0]  target_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] packed_pixel,
	output logic [1:0]  status
);
	logic [DimW-1:0] src_w_q, src_h_q, want_w_q, want_h_q;
	logic [5:0]      depth_q;
	logic [31:0]     rmask_q, gmask_q, bmask_q;
	logic            wr_en, job_valid, job_pop, back_busy;
	logic [AddrW-1:0] wr_addr;
	logic [PixW-1:0] wr_data;
	job_t            job;
	logic [2:0]      ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	// register file: write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 9'd256; src_h_q <= 9'd256; want_w_q <= '0; want_h_q <= '0;
			depth_q <= 6'd24; rmask_q <= 32'hFF0000; gmask_q <= 32'h00FF00;
			bmask_q <= 32'h0000FF;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_SRC_W:  src_w_q  <= pwdata[DimW-1:0];
				REG_SRC_H:  src_h_q  <= pwdata[DimW-1:0];
				REG_WANT_W: want_w_q <= pwdata[DimW-1:0];
				REG_WANT_H: want_h_q <= pwdata[DimW-1:0];
				REG_DEPTH:  depth_q  <= pwdata[5:0];
				REG_RMASK:  rmask_q  <= pwdata;
				REG_GMASK:  gmask_q  <= pwdata;
				REG_BMASK:  bmask_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_SRC_W:  prdata = 32'(src_w_q);
			REG_SRC_H:  prdata = 32'(src_h_q);
			REG_WANT_W: prdata = 32'(want_w_q);
			REG_WANT_H: prdata = 32'(want_h_q);
			REG_DEPTH:  prdata = 32'(depth_q);
			REG_RMASK:  prdata = rmask_q;
			REG_GMASK:  prdata = gmask_q;
			default:    prdata = bmask_q;
		endcase
	end

	aad_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .action(action),
		.source_index(source_index), .red_in(red_in), .green_in(green_in),
		.blue_in(blue_in), .target_col(target_col), .target_row(target_row),
		.src_w(src_w_q), .src_h(src_h_q), .want_w(want_w_q), .want_h(want_h_q),
		.depth(depth_q), .back_busy(back_busy), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(wr_data), .job_valid(job_valid), .job(job), .job_pop(job_pop)
	);

	aad_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_pop(job_pop), .busy(back_busy), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(wr_data), .rmask(rmask_q), .gmask(gmask_q), .bmask(bmask_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_pixel(packed_pixel),
		.out_status(status)
	);
endmodule

// ===== rtl/aad_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_front: intake and classification
// Writes load items into the pixel store, checks compute items, queues jobs.
// ----------------------------------------------------------------------------
module aad_front import aad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  logic             action,
	input  logic [15:0]      source_index,
	input  logic [7:0]       red_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       blue_in,
	input  logic [7:0]       target_col,
	input  logic [7:0]       target_row,
	input  logic [DimW-1:0]  src_w,
	input  logic [DimW-1:0]  src_h,
	input  logic [DimW-1:0]  want_w,
	input  logic [DimW-1:0]  want_h,
	input  logic [5:0]       depth,
	input  logic             back_busy,
	output logic             wr_en,
	output logic [AddrW-1:0] wr_addr,
	output logic [PixW-1:0]  wr_data,
	output logic             job_valid,
	output job_t             job,
	input  logic             job_pop
);
	localparam int QDepth = 2;
	job_t     q_q [QDepth];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [DimW-1:0] w, h, tw, th;
	job_t     nj;
	logic     push;

	always_comb begin
		w  = (src_w == '0) ? DimW'(1) : ((src_w > DimW'(MaxWidth)) ? DimW'(MaxWidth) : src_w);
		h  = (src_h == '0) ? DimW'(1) : ((src_h > DimW'(MaxHeight)) ? DimW'(MaxHeight) : src_h);
		tw = (want_w == '0 || want_w > w) ? w : want_w;
		th = (want_h == '0 || want_h > h) ? h : want_h;
		nj.w = w; nj.h = h; nj.tw = tw; nj.th = th;
		nj.col = target_col; nj.row = target_row;
		if (depth < 6'd24) begin
			nj.bad = 1'b1; nj.status = ST_DEPTH;
		end else if ({1'b0, target_col} >= tw || {1'b0, target_row} >= th) begin
			nj.bad = 1'b1; nj.status = ST_RANGE;
		end else begin
			nj.bad = 1'b0; nj.status = ST_OK;
		end
	end

	// hold loads while a compute job is queued or being walked
	assign stall     = (cnt_q == 2'(QDepth)) || (!action && (cnt_q != '0 || back_busy));
	assign push      = valid && !stall && action;
	assign wr_en     = valid && !stall && !action;
	assign wr_addr   = source_index;
	assign wr_data   = {red_in, green_in, blue_in};
	assign job_valid = (cnt_q != '0);
	assign job       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (job_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth)) else $error("queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(QDepth)) |-> !push) else $error("push into full queue");
endmodule

// ===== rtl/aad_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_divider: restoring divider
// One quotient bit per cycle; quotient truncated to 32 bits.
// ----------------------------------------------------------------------------
module aad_divider import aad_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [AccW+31:0]   num,
	input  logic [AreaW+7:0]   den,
	output logic               done,
	output logic [31:0]        quo
);
	localparam int NW = AccW + 32;
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0]     n_q;
	logic [AreaW+8:0]  r_q;
	logic [AreaW+7:0]  d_q;
	logic [31:0]       q_q;
	logic [CW-1:0]     c_q;
	logic              busy_q;
	logic [AreaW+8:0]  sh;
	logic              ge;

	assign sh   = {r_q[AreaW+7:0], n_q[NW-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign quo  = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num; d_q <= den; r_q <= '0; q_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= ge ? (sh - {1'b0, d_q}) : sh;
			q_q <= {q_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; c_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; c_q <= CW'(NW);
			end else if (busy_q) begin
				c_q <= c_q - 1'b1;
				if (c_q == CW'(1)) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/aad_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_back: footprint accumulation and packing
// Walks the footprint, reads the store, divides and packs each channel.
// ----------------------------------------------------------------------------
module aad_back import aad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  job_t             job,
	output logic             job_pop,
	output logic             busy,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [PixW-1:0]  wr_data,
	input  logic [31:0]      rmask,
	input  logic [31:0]      gmask,
	input  logic [31:0]      bmask,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      out_pixel,
	output logic [1:0]       out_status
);
	typedef enum logic [3:0] {
		S_IDLE, S_SPAN, S_SPAN2, S_ROW, S_COL, S_MAC, S_ROWEND, S_AREA,
		S_DIV, S_MUL, S_DWAIT, S_OUT
	} state_t;
	state_t state_q;

	logic [PixW-1:0] mem [2**AddrW];
	logic [PixW-1:0] rd_q;
	logic [AddrW-1:0] rd_addr;

	job_t             j_q;
	logic [17:0]      lox_q, hix_q, loy_q, hiy_q;
	logic [DimW-1:0]  c0_q, c1_q, r0_q, r1_q, c_q, r_q;
	logic [WtW-1:0]   wx_q, wy_q;
	logic [WtW+8:0]   sx_q, sy_q;
	logic [WtW+16:0]  rs_q [3];
	logic [AccW-1:0]  acc_q [3];
	logic [AreaW-1:0] area_q;
	logic [1:0]       k_q;
	logic [31:0]      pk_q;
	logic             rd_pend_q;

	// span divide: iterative over 9-bit dims
	logic [17:0]      dv_n_q;
	logic [DimW-1:0]  dv_d_q, dv_qq;
	logic [17:0]      dv_r_q;
	logic [4:0]       dv_c_q;
	logic [1:0]       sp_k_q;

	// weight division: (overlap << F) / src, sequential
	logic [17+FracBits:0] wn_q;
	logic [DimW-1:0]  wd_q;
	logic [WtW-1:0]   wq_q;
	logic [DimW:0]    wr_q;
	logic [5:0]       wc_q;
	logic             wsel_q;

	// channel sum times mask, one mask byte per cycle
	logic [AccW+31:0] prod_q;
	logic [1:0]       mb_q;

	logic             dstart;
	logic [AccW+31:0] dnum;
	logic [AreaW+7:0] dden;
	logic             ddone;
	logic [31:0]      dquo;
	logic [31:0]      mk;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign rd_addr = AddrW'(32'(r_q) * 32'(j_q.w) + 32'(c_q));
	assign job_pop = (state_q == S_IDLE) && job_valid && !out_valid;
	assign busy    = (state_q != S_IDLE);
	assign mk = (k_q == 2'd0) ? rmask : ((k_q == 2'd1) ? gmask : bmask);
	assign dnum = prod_q;
	assign dden = (AreaW + 8)'(area_q) * (AreaW + 8)'(255);

	aad_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	// overlap helper
	function automatic logic [17:0] ovl(input logic [17:0] lo, input logic [17:0] hi,
			input logic [17:0] clo, input logic [17:0] chi);
		logic [17:0] a, b;
		a = (lo > clo) ? lo : clo;
		b = (hi < chi) ? hi : chi;
		return (b > a) ? (b - a) : 18'd0;
	endfunction

	logic [17:0] ox, oy;
	assign ox = ovl(lox_q, hix_q, 18'(c_q) * 18'(j_q.tw), 18'(c_q + 1'b1) * 18'(j_q.tw));
	assign oy = ovl(loy_q, hiy_q, 18'(r_q) * 18'(j_q.th), 18'(r_q + 1'b1) * 18'(j_q.th));

	logic [DimW:0] wsh;
	assign wsh = {wr_q[DimW-1:0], wn_q[17+FracBits]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; dstart <= 1'b0; wc_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			dstart <= 1'b0;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (job_pop) begin
					j_q <= job;
					if (job.bad) begin
						out_pixel <= '0; out_status <= job.status; out_valid <= 1'b1;
					end else begin
						lox_q <= 18'(job.col) * 18'(job.w);
						hix_q <= 18'(job.col + 9'd1) * 18'(job.w);
						loy_q <= 18'(job.row) * 18'(job.h);
						hiy_q <= 18'(job.row + 9'd1) * 18'(job.h);
						sp_k_q <= 2'd0; dv_c_q <= '0;
						state_q <= S_SPAN;
					end
				end
				// four small divisions: c0, c1, r0, r1 (18 bits / 9 bits)
				S_SPAN: begin
					case (sp_k_q)
						2'd0: begin dv_n_q <= lox_q; dv_d_q <= j_q.tw; end
						2'd1: begin dv_n_q <= hix_q - 18'd1; dv_d_q <= j_q.tw; end
						2'd2: begin dv_n_q <= loy_q; dv_d_q <= j_q.th; end
						default: begin dv_n_q <= hiy_q - 18'd1; dv_d_q <= j_q.th; end
					endcase
					dv_r_q <= '0; dv_qq <= '0; dv_c_q <= 5'd18;
					state_q <= S_SPAN2;
				end
				S_SPAN2: begin
					if (dv_c_q != '0) begin
						logic [18:0] s;
						s = {dv_r_q, dv_n_q[17]};
						dv_n_q <= dv_n_q << 1;
						if (s >= 19'(dv_d_q)) begin
							dv_r_q <= 18'(s - 19'(dv_d_q)); dv_qq <= {dv_qq[DimW-2:0], 1'b1};
						end else begin
							dv_r_q <= 18'(s); dv_qq <= {dv_qq[DimW-2:0], 1'b0};
						end
						dv_c_q <= dv_c_q - 1'b1;
					end else begin
						case (sp_k_q)
							2'd0: c0_q <= dv_qq;
							2'd1: c1_q <= dv_qq;
							2'd2: r0_q <= dv_qq;
							default: r1_q <= dv_qq;
						endcase
						if (sp_k_q == 2'd3) begin
							for (int i = 0; i < 3; i++) acc_q[i] <= '0;
							sx_q <= '0; sy_q <= '0; k_q <= 2'd0;
							r_q <= r0_q; c_q <= c0_q;
							state_q <= S_ROW;
						end else begin
							sp_k_q <= sp_k_q + 1'b1;
							state_q <= S_SPAN;
						end
					end
				end
				// row weight
				S_ROW: begin
					if (wc_q == '0) begin
						wn_q <= {oy, {FracBits{1'b0}}}; wd_q <= j_q.h; wr_q <= '0;
						wq_q <= '0; wc_q <= 6'(18 + FracBits); wsel_q <= 1'b1;
					end else begin
						wn_q <= wn_q << 1;
						if (wsh >= (DimW+1)'(wd_q)) begin
							wr_q <= wsh - (DimW+1)'(wd_q); wq_q <= {wq_q[WtW-2:0], 1'b1};
						end else begin
							wr_q <= wsh; wq_q <= {wq_q[WtW-2:0], 1'b0};
						end
						wc_q <= wc_q - 1'b1;
						if (wc_q == 6'd1) begin
							for (int i = 0; i < 3; i++) rs_q[i] <= '0;
							c_q <= c0_q;
							state_q <= S_COL;
						end
					end
				end
				S_COL: begin
					if (wsel_q) begin
						wy_q <= wq_q; wsel_q <= 1'b0;
					end
					if (wc_q == '0) begin
						wn_q <= {ox, {FracBits{1'b0}}}; wd_q <= j_q.w; wr_q <= '0;
						wq_q <= '0; wc_q <= 6'(18 + FracBits);
					end else begin
						wn_q <= wn_q << 1;
						if (wsh >= (DimW+1)'(wd_q)) begin
							wr_q <= wsh - (DimW+1)'(wd_q); wq_q <= {wq_q[WtW-2:0], 1'b1};
						end else begin
							wr_q <= wsh; wq_q <= {wq_q[WtW-2:0], 1'b0};
						end
						wc_q <= wc_q - 1'b1;
						if (wc_q == 6'd1) state_q <= S_MAC;
					end
				end
				S_MAC: begin
					// store read registered from address of (r_q, c_q)
					if (!rd_pend_q) begin
						wx_q <= wq_q; rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						rs_q[0] <= rs_q[0] + (WtW+17)'(wx_q) * (WtW+17)'(rd_q[23:16]);
						rs_q[1] <= rs_q[1] + (WtW+17)'(wx_q) * (WtW+17)'(rd_q[15:8]);
						rs_q[2] <= rs_q[2] + (WtW+17)'(wx_q) * (WtW+17)'(rd_q[7:0]);
						if (r_q == r0_q) sx_q <= sx_q + (WtW+9)'(wx_q);
						if (c_q == c1_q) state_q <= S_ROWEND;
						else begin
							c_q <= c_q + 1'b1; state_q <= S_COL;
						end
					end
				end
				S_ROWEND: begin
					if (k_q == 2'd0 && !rd_pend_q) begin
						sy_q <= sy_q + (WtW+9)'(wy_q);
					end
					acc_q[k_q] <= acc_q[k_q] + AccW'(rs_q[k_q]) * AccW'(wy_q);
					if (k_q == 2'd2) begin
						k_q <= 2'd0;
						if (r_q == r1_q) state_q <= S_AREA;
						else begin
							r_q <= r_q + 1'b1; state_q <= S_ROW;
						end
					end else k_q <= k_q + 1'b1;
				end
				S_AREA: begin
					area_q <= AreaW'(sx_q) * AreaW'(sy_q);
					pk_q <= '0; k_q <= 2'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (area_q == '0) begin
						out_pixel <= '0; out_status <= ST_OK; out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						prod_q <= '0; mb_q <= 2'd3; state_q <= S_MUL;
					end
				end
				// multiply the channel sum by its mask, top byte first
				S_MUL: begin
					prod_q <= (prod_q << 8) + (AccW+32)'((AccW+8)'(acc_q[k_q]) *
						(AccW+8)'(mk[{mb_q, 3'b000} +: 8]));
					if (mb_q == 2'd0) begin
						dstart <= 1'b1; state_q <= S_DWAIT;
					end else mb_q <= mb_q - 1'b1;
				end
				S_DWAIT: if (ddone) begin
					if (k_q == 2'd2) begin
						out_pixel <= pk_q | (dquo & mk); out_status <= ST_OK;
						out_valid <= 1'b1; k_q <= 2'd0; state_q <= S_IDLE;
					end else begin
						pk_q <= pk_q | (dquo & mk); k_q <= k_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !out_valid) else $error("pop with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (c_q <= c1_q)) else $error("column past span");
endmodule
